FILE: rtl/dsa_pkg.sv
// dsa_pkg: shared types and constants of the display slot allocator
// no dependencies; used by dsa_front, dsa_queue, dsa_back and the top level
package dsa_pkg;

  localparam int CNT_W  = 5;   // width of the slot count register
  localparam int ID_W   = 32;
  localparam int POS_W  = 16;
  localparam int SIDX_W = 4;   // slot index as seen on the ports

  typedef enum logic [2:0] {
    ACT_LOAD      = 3'd0,
    ACT_ALLOC     = 3'd1,
    ACT_REL_CHAN  = 3'd2,
    ACT_REL_USER  = 3'd3,
    ACT_FIND_CHAN = 3'd4,
    ACT_FIND_USER = 3'd5,
    ACT_SET_SAVE  = 3'd6,
    ACT_READ      = 3'd7
  } action_t;

  typedef enum logic {
    KIND_DIRECT = 1'b0,
    KIND_SCAN   = 1'b1
  } kind_t;

  // one decoded word as it travels from the front to the back
  typedef struct packed {
    action_t                   action;
    kind_t                     kind;
    logic                      by_user;
    logic                      idx_ok;
    logic [ID_W-1:0]           chan;
    logic [ID_W-1:0]           user;
    logic [SIDX_W-1:0]         slot_idx;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic                      save;
  } cmd_t;

  typedef struct packed {
    logic                      ok;
    logic [SIDX_W-1:0]         idx;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic [ID_W-1:0]           chan;
    logic [ID_W-1:0]           user;
    logic                      used;
    logic                      saved;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SCAN  = 3'd1,
    ST_EXEC  = 3'd2,
    ST_FETCH = 3'd3,
    ST_RESP  = 3'd4
  } back_state_t;

endpackage

FILE: rtl/dsa_front.sv
// dsa_front: slot count register, input acceptance and command decode
// depends on dsa_pkg; feeds dsa_queue
module dsa_front #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dsa_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_action,
  input  logic [dsa_pkg::ID_W-1:0]      in_chan_id,
  input  logic [dsa_pkg::ID_W-1:0]      in_user_id,
  input  logic [dsa_pkg::SIDX_W-1:0]    in_slot_index,
  input  logic signed [dsa_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [dsa_pkg::POS_W-1:0] in_pos_y,
  input  logic                          in_save_flag,
  input  logic                          q_full,
  output logic                          q_push,
  output dsa_pkg::cmd_t                 q_cmd,
  output logic [dsa_pkg::CNT_W-1:0]     act_cnt
);
  import dsa_pkg::*;

  // largest count the register can hold, capped by the table depth
  localparam int CAP = (SLOTS < ((1 << CNT_W) - 1)) ? SLOTS : ((1 << CNT_W) - 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

  logic [CNT_W-1:0] slot_count_r;
  action_t          act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= '0;
    end else if (cfg_we) begin
      slot_count_r <= cfg_wdata;
    end
  end

  assign act_cnt  = (slot_count_r > CAP_C) ? CAP_C : slot_count_r;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign act      = action_t'(in_action);

  always_comb begin
    q_cmd          = '0;
    q_cmd.action   = act;
    q_cmd.chan     = in_chan_id;
    q_cmd.user     = in_user_id;
    q_cmd.slot_idx = in_slot_index;
    q_cmd.x        = in_pos_x;
    q_cmd.y        = in_pos_y;
    q_cmd.save     = in_save_flag;
    q_cmd.by_user  = act inside {ACT_REL_USER, ACT_FIND_USER};
    q_cmd.idx_ok   = {1'b0, in_slot_index} < act_cnt;
    case (act)
      ACT_LOAD, ACT_SET_SAVE, ACT_READ: begin
        q_cmd.kind = KIND_DIRECT;
      end
      default: begin
        q_cmd.kind = KIND_SCAN;
      end
    endcase
  end

endmodule

FILE: rtl/dsa_queue.sv
// dsa_queue: two-entry command queue between front and back
// depends on dsa_pkg
module dsa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dsa_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dsa_pkg::cmd_t head_cmd
);
  import dsa_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r[1];
  assign empty    = (cnt_r == 2'd0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/dsa_back.sv
// dsa_back: slot table, scan sequencer and result register
// depends on dsa_pkg; takes decoded words from dsa_queue
module dsa_back #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dsa_pkg::CNT_W-1:0]     act_cnt,
  input  dsa_pkg::cmd_t                 q_cmd,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [dsa_pkg::SIDX_W-1:0]    out_found_index,
  output logic signed [dsa_pkg::POS_W-1:0] out_x,
  output logic signed [dsa_pkg::POS_W-1:0] out_y,
  output logic [dsa_pkg::ID_W-1:0]      out_chan,
  output logic [dsa_pkg::ID_W-1:0]      out_user,
  output logic                          out_used,
  output logic                          out_saved
);
  import dsa_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  back_state_t       st_r, st_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic              fail_r, fail_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;

  logic              used_r [SLOTS];
  logic              save_r [SLOTS];
  logic [2*ID_W-1:0] id_mem [SLOTS];
  logic [2*POS_W-1:0] pos_mem [SLOTS];
  logic [2*ID_W-1:0] id_q;
  logic [2*POS_W-1:0] pos_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              exec_en;

  logic              chk_used, chan_eq, user_eq, key_eq;
  logic              hit_used, hit_saved;

  assign chk_used  = used_r[chk_idx_r];
  assign chan_eq   = (id_q[2*ID_W-1:ID_W] == cmd_r.chan);
  assign user_eq   = (id_q[ID_W-1:0] == cmd_r.user);
  assign key_eq    = cmd_r.by_user ? user_eq : chan_eq;
  assign hit_used  = used_r[hit_idx_r];
  assign hit_saved = save_r[hit_idx_r];

  // one slot read per cycle while scanning, else the chosen slot
  assign rd_addr = (st_r == ST_SCAN) ? IDX_W'(ptr_r) : hit_idx_r;

  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    ptr_nxt       = ptr_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    hit_idx_nxt   = hit_idx_r;
    fail_nxt      = fail_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    exec_en       = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_IDLE: begin
        chk_vld_nxt = 1'b0;
        if (!q_empty) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          fail_nxt    = 1'b0;
          ptr_nxt     = '0;
          hit_idx_nxt = IDX_W'(q_cmd.slot_idx);
          if (q_cmd.kind == KIND_SCAN) begin
            st_nxt = ST_SCAN;
          end else if (!q_cmd.idx_ok) begin
            fail_nxt = 1'b1;
            st_nxt   = ST_RESP;
          end else if (q_cmd.action == ACT_READ) begin
            st_nxt = ST_FETCH;
          end else begin
            st_nxt = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        // the slot read last cycle is checked while the next one is read
        if (chk_vld_r && cmd_r.action == ACT_ALLOC && !chk_used) begin
          hit_idx_nxt = chk_idx_r;
          st_nxt      = ST_EXEC;
        end else if (chk_vld_r && cmd_r.action == ACT_ALLOC && chan_eq && user_eq) begin
          fail_nxt = 1'b1;
          st_nxt   = ST_RESP;
        end else if (chk_vld_r && cmd_r.action != ACT_ALLOC && chk_used && key_eq) begin
          hit_idx_nxt = chk_idx_r;
          if (cmd_r.action == ACT_FIND_CHAN || cmd_r.action == ACT_FIND_USER) begin
            st_nxt = ST_FETCH;
          end else begin
            st_nxt = ST_EXEC;
          end
        end else if (!chk_vld_r && ptr_r >= act_cnt) begin
          fail_nxt = 1'b1;
          st_nxt   = ST_RESP;
        end else begin
          chk_vld_nxt = (ptr_r < act_cnt);
          chk_idx_nxt = IDX_W'(ptr_r);
          if (ptr_r < act_cnt) begin
            ptr_nxt = ptr_r + CNT_W'(1);
          end
        end
      end
      ST_EXEC: begin
        exec_en = 1'b1;
        st_nxt  = ST_FETCH;
      end
      ST_FETCH: begin
        st_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          if (!fail_r) begin
            res_nxt.ok    = 1'b1;
            res_nxt.idx   = SIDX_W'(hit_idx_r);
            res_nxt.x     = pos_q[2*POS_W-1:POS_W];
            res_nxt.y     = pos_q[POS_W-1:0];
            // ids of a free slot always read as zero
            res_nxt.chan  = hit_used ? id_q[2*ID_W-1:ID_W] : '0;
            res_nxt.user  = hit_used ? id_q[ID_W-1:0] : '0;
            res_nxt.used  = hit_used;
            res_nxt.saved = hit_saved;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      fail_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      fail_r      <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    ptr_r     <= ptr_nxt;
    chk_idx_r <= chk_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    res_r     <= res_nxt;
  end

  // marks live in flops so reset clears them at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_r[i] <= 1'b0;
        save_r[i] <= 1'b0;
      end
    end else if (exec_en) begin
      case (cmd_r.action)
        ACT_LOAD, ACT_REL_CHAN, ACT_REL_USER: begin
          used_r[hit_idx_r] <= 1'b0;
          save_r[hit_idx_r] <= 1'b0;
        end
        ACT_ALLOC: begin
          used_r[hit_idx_r] <= 1'b1;
        end
        ACT_SET_SAVE: begin
          save_r[hit_idx_r] <= cmd_r.save;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en && cmd_r.action == ACT_ALLOC) begin
      id_mem[hit_idx_r] <= {cmd_r.chan, cmd_r.user};
    end
    id_q <= id_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (exec_en && cmd_r.action == ACT_LOAD) begin
      pos_mem[hit_idx_r] <= {cmd_r.x, cmd_r.y};
    end
    pos_q <= pos_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = res_r.ok;
  assign out_found_index = res_r.idx;
  assign out_x           = res_r.x;
  assign out_y           = res_r.y;
  assign out_chan        = res_r.chan;
  assign out_user        = res_r.user;
  assign out_used        = res_r.used;
  assign out_saved       = res_r.saved;

  a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (int'(chk_idx_r) < int'(act_cnt)))
    else $error("scan checks a slot beyond the active count");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RESP && !fail_r && cmd_r.action == ACT_ALLOC) |-> hit_used)
    else $error("allocated slot not marked used");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RESP && !fail_r &&
     (cmd_r.action == ACT_REL_CHAN || cmd_r.action == ACT_REL_USER))
    |-> (!hit_used && !hit_saved))
    else $error("released slot still holds marks");

  a_exec_not_failed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EXEC) |-> !fail_r)
    else $error("table update on a failed command");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r != ST_IDLE))
    else $error("command popped but sequencer stayed idle");

endmodule

FILE: rtl/display_slot_allocator.sv
// display_slot_allocator: top level of the display slot table
// depends on dsa_pkg, dsa_front, dsa_queue and dsa_back
//
// Usage: commands enter on the in_ channel (valid/ready) and each gives
// exactly one result word on the out_ channel (valid/ready). The slot count
// is written through cfg_we/cfg_wdata while no command is in flight.
// The front registers the count, decodes the command and checks its index,
// then pushes it into a two-entry queue, so the input keeps accepting while
// the table works. The back runs one command at a time.
// Load, set save and read address their slot directly, and a bad index is
// answered without touching the table; allocate, release and find scan the
// slots one per cycle through the single read port of the id memory, so the
// time they take grows with the active count.
// Reset (synchronous, rst_n low) clears the slot count, the queue, all used
// and save marks and the result valid flag; positions stay undefined until a
// load writes them. When the receiver holds out_ready low the result word
// stays put, the back stops after finishing its next command, and the input
// stalls once the queue is full.
module display_slot_allocator #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [4:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_action,
  input  logic [31:0]                   in_chan_id,
  input  logic [31:0]                   in_user_id,
  input  logic [3:0]                    in_slot_index,
  input  logic signed [15:0]            in_pos_x,
  input  logic signed [15:0]            in_pos_y,
  input  logic                          in_save_flag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [3:0]                    out_found_index,
  output logic signed [15:0]            out_x,
  output logic signed [15:0]            out_y,
  output logic [31:0]                   out_chan,
  output logic [31:0]                   out_user,
  output logic                          out_used,
  output logic                          out_saved
);
  import dsa_pkg::*;

  cmd_t             push_cmd, head_cmd;
  logic             q_push, q_pop, q_full, q_empty;
  logic [CNT_W-1:0] act_cnt;

  dsa_front #(.SLOTS(SLOTS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_chan_id    (in_chan_id),
    .in_user_id    (in_user_id),
    .in_slot_index (in_slot_index),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_save_flag  (in_save_flag),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd),
    .act_cnt       (act_cnt)
  );

  dsa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  dsa_back #(.SLOTS(SLOTS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .act_cnt         (act_cnt),
    .q_cmd           (head_cmd),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_found_index (out_found_index),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_chan        (out_chan),
    .out_user        (out_user),
    .out_used        (out_used),
    .out_saved       (out_saved)
  );

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for display_slot_allocator
// depends on rtl/dsa_pkg.sv and rtl/display_slot_allocator.sv; a slot table
// model predicts every result word, which is checked in arrival order
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsa_pkg::*;

  localparam int SLOTS      = 16;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL       = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_we = 1'b0;
  logic [4:0]               cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_action = '0;
  logic [31:0]              in_chan_id = '0;
  logic [31:0]              in_user_id = '0;
  logic [3:0]               in_slot_index = '0;
  logic signed [15:0]       in_pos_x = '0;
  logic signed [15:0]       in_pos_y = '0;
  logic                     in_save_flag = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_ok;
  logic [3:0]               out_found_index;
  logic signed [15:0]       out_x;
  logic signed [15:0]       out_y;
  logic [31:0]              out_chan;
  logic [31:0]              out_user;
  logic                     out_used;
  logic                     out_saved;

  // slot table as the bench sees it
  logic [4:0]               slot_count_q;
  logic                     slot_used[SLOTS];
  logic                     slot_saved[SLOTS];
  logic [31:0]              slot_chan[SLOTS];
  logic [31:0]              slot_user[SLOTS];
  logic signed [15:0]       slot_x[SLOTS];
  logic signed [15:0]       slot_y[SLOTS];
  bit                       slot_loaded[SLOTS];

  result_t                  pending_results[$];
  int                       mismatches = 0;
  int                       idle_cycles = 0;
  int                       send_idle_pct = 0;
  int                       stall_pct = 0;
  bit                       hold_go = 1'b0;
  int                       hold_cnt = 0;
  logic [31:0]              chan_pool[4];
  logic [31:0]              user_pool[4];

  display_slot_allocator #(.SLOTS(SLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_chan_id      (in_chan_id),
    .in_user_id      (in_user_id),
    .in_slot_index   (in_slot_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_save_flag    (in_save_flag),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_found_index (out_found_index),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_chan        (out_chan),
    .out_user        (out_user),
    .out_used        (out_used),
    .out_saved       (out_saved)
  );

  always #10ns clk = ~clk;

  function automatic int active_slots();
    return (int'(slot_count_q) > SLOTS) ? SLOTS : int'(slot_count_q);
  endfunction

  // applies one command to the slot table and returns the word it answers with
  function automatic result_t apply_command(action_t act, logic [31:0] chan,
                                            logic [31:0] user, logic [3:0] sidx,
                                            logic signed [15:0] px,
                                            logic signed [15:0] py, logic sflag);
    result_t r;
    int      n;
    int      hit;
    bit      done;
    bit      by_user;
    r = '0;
    hit = -1;
    done = 1'b0;
    n = active_slots();
    by_user = (act == ACT_REL_USER) || (act == ACT_FIND_USER);
    case (act)
      ACT_LOAD: begin
        if (int'(sidx) < n) begin
          slot_used[sidx] = 1'b0;
          slot_saved[sidx] = 1'b0;
          slot_chan[sidx] = '0;
          slot_user[sidx] = '0;
          slot_x[sidx] = px;
          slot_y[sidx] = py;
          slot_loaded[sidx] = 1'b1;
          hit = int'(sidx);
        end
      end
      ACT_ALLOC: begin
        for (int i = 0; i < n && !done; i++) begin
          if (slot_used[i]) begin
            // same channel and user already held: duplicate
            if (slot_chan[i] == chan && slot_user[i] == user) done = 1'b1;
          end else begin
            slot_used[i] = 1'b1;
            slot_chan[i] = chan;
            slot_user[i] = user;
            hit = i;
            done = 1'b1;
          end
        end
      end
      ACT_REL_CHAN, ACT_REL_USER, ACT_FIND_CHAN, ACT_FIND_USER: begin
        for (int i = 0; i < n && hit < 0; i++) begin
          if (slot_used[i] && (by_user ? slot_user[i] == user : slot_chan[i] == chan))
            hit = i;
        end
        if (hit >= 0 && (act == ACT_REL_CHAN || act == ACT_REL_USER)) begin
          slot_used[hit] = 1'b0;
          slot_saved[hit] = 1'b0;
          slot_chan[hit] = '0;
          slot_user[hit] = '0;
        end
      end
      ACT_SET_SAVE: begin
        if (int'(sidx) < n) begin
          slot_saved[sidx] = sflag;
          hit = int'(sidx);
        end
      end
      default: begin
        if (int'(sidx) < n) hit = int'(sidx);
      end
    endcase
    if (hit >= 0) begin
      r.ok = 1'b1;
      r.idx = hit[3:0];
      r.x = slot_x[hit];
      r.y = slot_y[hit];
      r.chan = slot_chan[hit];
      r.user = slot_user[hit];
      r.used = slot_used[hit];
      r.saved = slot_saved[hit];
    end
    return r;
  endfunction

  task automatic flag_error(string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endtask

  // offers one word and waits for it to be taken; valid stays high on return
  task automatic send_command(action_t act, logic [31:0] chan, logic [31:0] user,
                              logic [3:0] sidx, logic signed [15:0] px,
                              logic signed [15:0] py, logic sflag);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_chan_id <= chan;
    in_user_id <= user;
    in_slot_index <= sidx;
    in_pos_x <= px;
    in_pos_y <= py;
    in_save_flag <= sflag;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_command(act, chan, user, sidx, px, py, sflag));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let the back end settle before touching the count
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic set_slot_count(logic [4:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_count_q = value;
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    send_idle_pct = tx_pct;
    stall_pct = rx_pct;
  endtask

  // every active slot gets a position before anything can read it
  task automatic load_unloaded_slots();
    for (int i = 0; i < active_slots(); i++) begin
      if (!slot_loaded[i])
        send_command(ACT_LOAD, '0, '0, i[3:0], 16'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  task automatic refresh_pools();
    foreach (chan_pool[k]) chan_pool[k] = $urandom;
    foreach (user_pool[k]) user_pool[k] = $urandom;
    chan_pool[0] = '0;
    user_pool[3] = '1;
  endtask

  function automatic logic signed [15:0] pick_pos();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'sh8000;
    if (r < 16) return 16'sh7fff;
    return 16'($urandom);
  endfunction

  // ids mostly come from small pools so that finds, releases and duplicates hit
  task automatic run_random(int count);
    int          r;
    int          n;
    action_t     act;
    logic [31:0] chan;
    logic [31:0] user;
    logic [3:0]  sidx;
    refresh_pools();
    for (int k = 0; k < count; k++) begin
      n = active_slots();
      r = $urandom_range(99);
      if (r < 30) act = ACT_ALLOC;
      else if (r < 40) act = ($urandom_range(1) != 0) ? ACT_REL_USER : ACT_REL_CHAN;
      else if (r < 55) act = ($urandom_range(1) != 0) ? ACT_FIND_USER : ACT_FIND_CHAN;
      else if (r < 63) act = ACT_LOAD;
      else if (r < 77) act = ACT_SET_SAVE;
      else act = ACT_READ;
      chan = ($urandom_range(99) < 8) ? $urandom : chan_pool[$urandom_range(3)];
      user = ($urandom_range(99) < 8) ? $urandom : user_pool[$urandom_range(3)];
      if (n > 0 && $urandom_range(99) < 75) sidx = 4'($urandom_range(n - 1));
      else sidx = 4'($urandom_range(15));
      send_command(act, chan, user, sidx, pick_pos(), pick_pos(), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    // nothing active right after reset
    send_command(ACT_READ, '0, '0, 4'd0, '0, '0, 1'b0);
    send_command(ACT_ALLOC, 32'd1, 32'd1, '0, '0, '0, 1'b0);
    set_slot_count(5'd4);
    send_command(ACT_LOAD, '0, '0, 4'd0, 16'sh8000, 16'sh7fff, 1'b0);
    send_command(ACT_LOAD, '0, '0, 4'd1, 16'sh7fff, 16'sh8000, 1'b0);
    send_command(ACT_LOAD, '0, '0, 4'd2, 16'sh0000, 16'shffff, 1'b0);
    send_command(ACT_LOAD, '0, '0, 4'd3, 16'shffff, 16'sh0000, 1'b0);
    // index equal to the count is out of range
    send_command(ACT_LOAD, '0, '0, 4'd4, 16'sh1234, 16'sh4321, 1'b0);
    send_command(ACT_ALLOC, 32'h0, 32'h0, '0, '0, '0, 1'b0);
    send_command(ACT_ALLOC, 32'h0, 32'h0, '0, '0, '0, 1'b0);
    send_command(ACT_ALLOC, 32'h0, 32'hffff_ffff, '0, '0, '0, 1'b0);
    send_command(ACT_ALLOC, 32'hffff_ffff, 32'hffff_ffff, '0, '0, '0, 1'b0);
    send_command(ACT_ALLOC, 32'h1234_5678, 32'h9abc_def0, '0, '0, '0, 1'b0);
    // table full
    send_command(ACT_ALLOC, 32'd1, 32'd1, '0, '0, '0, 1'b0);
    send_command(ACT_FIND_CHAN, 32'h0, '0, '0, '0, '0, 1'b0);
    send_command(ACT_FIND_USER, '0, 32'hffff_ffff, '0, '0, '0, 1'b0);
    send_command(ACT_FIND_USER, '0, 32'd5, '0, '0, '0, 1'b0);
    send_command(ACT_SET_SAVE, '0, '0, 4'd1, '0, '0, 1'b1);
    send_command(ACT_READ, '0, '0, 4'd1, '0, '0, 1'b0);
    send_command(ACT_SET_SAVE, '0, '0, 4'd4, '0, '0, 1'b1);
    send_command(ACT_READ, '0, '0, 4'd15, '0, '0, 1'b0);
    send_command(ACT_REL_CHAN, 32'h0, '0, '0, '0, '0, 1'b0);
    send_command(ACT_REL_USER, '0, 32'hffff_ffff, '0, '0, '0, 1'b0);
    send_command(ACT_REL_CHAN, 32'd7, '0, '0, '0, '0, 1'b0);
    send_command(ACT_ALLOC, 32'd7, 32'd7, '0, '0, '0, 1'b0);
    // load over a used slot wipes ids and marks
    send_command(ACT_LOAD, '0, '0, 4'd2, 16'sh0101, 16'sh0202, 1'b0);
    send_command(ACT_READ, '0, '0, 4'd2, '0, '0, 1'b0);
  endtask

  task automatic test_full_table();
    set_slot_count(5'd16);
    set_idling(0, 0);
    load_unloaded_slots();
    run_random(260);
  endtask

  task automatic test_saturated_count();
    set_slot_count(5'd31);
    set_idling(87, 0);
    load_unloaded_slots();
    run_random(240);
  endtask

  task automatic test_single_slot();
    set_slot_count(5'd1);
    set_idling(0, 87);
    load_unloaded_slots();
    run_random(150);
  endtask

  task automatic test_mixed_counts();
    repeat (3) begin
      set_slot_count(5'($urandom_range(2, 15)));
      set_idling(6, 6);
      load_unloaded_slots();
      run_random(100);
    end
  endtask

  task automatic test_zero_count();
    set_slot_count(5'd0);
    set_idling(0, 0);
    run_random(50);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    set_slot_count(5'd17);
    set_idling(0, 0);
    load_unloaded_slots();
    hold_go = 1'b1;
    run_random(200);
  endtask

  // lowered count hides upper slots, raising it brings them back intact
  task automatic test_count_changes();
    set_slot_count(5'd16);
    set_idling(87, 0);
    run_random(80);
    set_slot_count(5'd3);
    set_idling(0, 87);
    run_random(60);
    set_slot_count(5'd16);
    set_idling(6, 6);
    run_random(80);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (hold_go && hold_cnt < HOLD_LEN) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // each result word against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.ok = out_ok;
      got.idx = out_found_index;
      got.x = out_x;
      got.y = out_y;
      got.chan = out_chan;
      got.user = out_user;
      got.used = out_used;
      got.saved = out_saved;
      if (pending_results.size() == 0) begin
        flag_error("unexpected result word with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_error($sformatf({"mismatch: expected ok=%0b idx=%0d x=%0d y=%0d chan=%h ",
                                "user=%h used=%0b saved=%0b, got ok=%0b idx=%0d x=%0d ",
                                "y=%0d chan=%h user=%h used=%0b saved=%0b"},
                               want.ok, want.idx, want.x, want.y, want.chan, want.user,
                               want.used, want.saved, got.ok, got.idx, got.x, got.y,
                               got.chan, got.user, got.used, got.saved));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[display_slot_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    slot_count_q = '0;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_saved[i] = 1'b0;
      slot_chan[i] = '0;
      slot_user[i] = '0;
      slot_x[i] = '0;
      slot_y[i] = '0;
      slot_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_saturated_count();
    test_single_slot();
    test_mixed_counts();
    test_zero_count();
    test_backpressure();
    test_count_changes();
    drain();
    if (mismatches == 0) begin
      $display("[display_slot_allocator] OK");
    end else begin
      $display("[display_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule
